// File: rtl/core/pdb_pkg.sv
// ---------------------------------------------------------------------------
// pdb_pkg
// shared types, register map and mode decode for the porter-duff pixel blend
// ---------------------------------------------------------------------------
package pdb_pkg;

	// apb register map
	localparam int unsigned ADDR_W       = 3;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned MODE_W       = 4;
	localparam logic        REG_IDX_MODE = 1'b0;
	localparam logic [MODE_W-1:0] MODE_RESET = 4'd3;

	// saturation bound for the rounded atop / xor path (255 * 256)
	localparam logic [17:0] RND_SAT_LIMIT = 18'd65280;
	localparam logic [17:0] RND_BIAS      = 18'd127;

	typedef enum logic [MODE_W-1:0] {
		PD_CLEAR   = 4'd0,
		PD_SRC     = 4'd1,
		PD_DST     = 4'd2,
		PD_SRCOVER = 4'd3,
		PD_DSTOVER = 4'd4,
		PD_SRCIN   = 4'd5,
		PD_DSTIN   = 4'd6,
		PD_SRCOUT  = 4'd7,
		PD_DSTOUT  = 4'd8,
		PD_SRCATOP = 4'd9,
		PD_DSTATOP = 4'd10,
		PD_XOR     = 4'd11
	} pd_mode_t;

	// per-pixel context shared by all four channels in the combine stage
	typedef struct packed {
		pd_mode_t mode;
		logic     sa_zero;
		logic     sa_full;
		logic     da_zero;
		logic     da_full;
	} pd_ctx_t;

	// unused codes fall back to source-over
	function automatic pd_mode_t decode_mode(input logic [MODE_W-1:0] code);
		pd_mode_t m;
		unique case (code)
			4'd0:    m = PD_CLEAR;
			4'd1:    m = PD_SRC;
			4'd2:    m = PD_DST;
			4'd3:    m = PD_SRCOVER;
			4'd4:    m = PD_DSTOVER;
			4'd5:    m = PD_SRCIN;
			4'd6:    m = PD_DSTIN;
			4'd7:    m = PD_SRCOUT;
			4'd8:    m = PD_DSTOUT;
			4'd9:    m = PD_SRCATOP;
			4'd10:   m = PD_DSTATOP;
			4'd11:   m = PD_XOR;
			default: m = PD_SRCOVER;
		endcase
		return m;
	endfunction

endpackage

// File: rtl/core/pdb_channel.sv
// ---------------------------------------------------------------------------
// pdb_channel
// one color or alpha channel: operand select and multiply, product register,
// then mode combine with rounding and saturation
// ---------------------------------------------------------------------------
module pdb_channel (
	input  logic                clk,
	input  logic                adv_s2,
	input  logic [7:0]          s_s1,
	input  logic [7:0]          d_s1,
	input  logic [7:0]          sa_s1,
	input  logic [7:0]          da_s1,
	input  pdb_pkg::pd_mode_t   mode_s1,
	input  pdb_pkg::pd_ctx_t    ctx_s2,
	output logic [7:0]          res
);

	logic [7:0]  op_x, op_a, op_y, op_b;
	logic [15:0] prod_a_s2, prod_b_s2;
	logic [7:0]  s_s2, d_s2;
	logic [7:0]  hi;
	logic [16:0] sum_p;
	logic [17:0] rnd_n;
	logic [17:0] rnd_t;
	logic [7:0]  rnd_q;

	// operand select, 255 - alpha is the bitwise inverse
	always_comb begin
		op_x = '0;
		op_a = '0;
		op_y = '0;
		op_b = '0;
		unique case (mode_s1)
			pdb_pkg::PD_SRCOVER: begin op_x = d_s1; op_a = ~sa_s1; end
			pdb_pkg::PD_DSTOVER: begin op_x = s_s1; op_a = ~da_s1; end
			pdb_pkg::PD_SRCIN:   begin op_x = s_s1; op_a = da_s1;  end
			pdb_pkg::PD_DSTIN:   begin op_x = d_s1; op_a = sa_s1;  end
			pdb_pkg::PD_SRCOUT:  begin op_x = s_s1; op_a = ~da_s1; end
			pdb_pkg::PD_DSTOUT:  begin op_x = d_s1; op_a = ~sa_s1; end
			pdb_pkg::PD_SRCATOP: begin
				op_x = s_s1; op_a = da_s1;
				op_y = d_s1; op_b = ~sa_s1;
			end
			pdb_pkg::PD_DSTATOP: begin
				op_x = d_s1; op_a = sa_s1;
				op_y = s_s1; op_b = ~da_s1;
			end
			pdb_pkg::PD_XOR: begin
				op_x = s_s1; op_a = ~da_s1;
				op_y = d_s1; op_b = ~sa_s1;
			end
			default: begin end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			prod_a_s2 <= op_x * op_a;
			prod_b_s2 <= op_y * op_b;
			s_s2      <= s_s1;
			d_s2      <= d_s1;
		end
	end

	assign hi = prod_a_s2[15:8];

	// floor((2p+255)/510) == floor((p+127)/255); exact shift-add below the limit
	assign sum_p = {1'b0, prod_a_s2} + {1'b0, prod_b_s2};
	assign rnd_n = {1'b0, sum_p} + pdb_pkg::RND_BIAS;
	assign rnd_t = rnd_n + 18'd1 + {8'd0, rnd_n[17:8]};
	assign rnd_q = (rnd_n >= pdb_pkg::RND_SAT_LIMIT) ? 8'hFF : rnd_t[15:8];

	always_comb begin
		res = '0;
		unique case (ctx_s2.mode)
			pdb_pkg::PD_CLEAR: res = '0;
			pdb_pkg::PD_SRC:   res = s_s2;
			pdb_pkg::PD_DST:   res = d_s2;
			pdb_pkg::PD_SRCOVER: begin
				priority if (ctx_s2.sa_zero) res = d_s2;
				else if (ctx_s2.sa_full)     res = s_s2;
				else                         res = s_s2 + hi;
			end
			pdb_pkg::PD_DSTOVER: begin
				priority if (ctx_s2.da_zero) res = s_s2;
				else if (ctx_s2.da_full)     res = d_s2;
				else                         res = d_s2 + hi;
			end
			pdb_pkg::PD_SRCIN,
			pdb_pkg::PD_DSTIN:
				res = (ctx_s2.sa_zero || ctx_s2.da_zero) ? 8'd0 : hi;
			pdb_pkg::PD_SRCOUT: res = ctx_s2.sa_zero ? 8'd0 : hi;
			pdb_pkg::PD_DSTOUT: res = ctx_s2.da_zero ? 8'd0 : hi;
			default:            res = rnd_q;
		endcase
	end

endmodule

// File: rtl/core/porter_duff_pixel_blend.sv
// ---------------------------------------------------------------------------
// porter_duff_pixel_blend
// porter-duff compositing of one premultiplied argb8888 pixel pair per item
// ---------------------------------------------------------------------------
// Takes one source and one destination pixel per item and returns one blended
// pixel under the mode held in blend_mode (apb byte address 0, reset srcover,
// codes 12 to 15 behave as srcover). Throughput is one item per clock while the
// output is not stalled. An accepted item passes through the input register,
// then the product register after the two 8x8 multipliers of each channel, and
// then the result register, which drives out_valid, after the mode combine and
// the rounding divide by 255. The result register and the pipeline registers
// each take a new item when they are empty or the stage ahead of them moves,
// so input acceptance continues while a result waits as long as one stage is
// still free.
// blend_mode may only be rewritten while the pipeline is empty.
// ---------------------------------------------------------------------------
module porter_duff_pixel_blend (
	input  logic        clk,
	input  logic        arst_n,

	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	// pixel input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  src_alpha,
	input  logic [7:0]  src_red,
	input  logic [7:0]  src_green,
	input  logic [7:0]  src_blue,
	input  logic [7:0]  dst_alpha,
	input  logic [7:0]  dst_red,
	input  logic [7:0]  dst_green,
	input  logic [7:0]  dst_blue,

	// blended pixel output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_alpha,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue
);

	// configuration register
	logic [pdb_pkg::MODE_W-1:0] blend_mode_q;
	logic                       reg_sel;
	logic                       cfg_wr;

	// pipeline control
	logic adv_s1, adv_s2, adv_s3;
	logic valid_s1, valid_s2, out_valid_q;

	// stage 1: registered item plus decoded mode
	logic [7:0]          sa_s1, sr_s1, sg_s1, sb_s1;
	logic [7:0]          da_s1, dr_s1, dg_s1, db_s1;
	pdb_pkg::pd_mode_t   mode_s1;

	// stage 2: per-pixel context for the combine
	pdb_pkg::pd_ctx_t    ctx_s2;

	// channel results before the output register
	logic [7:0] res_a, res_r, res_g, res_b;
	logic [7:0] out_a_q, out_r_q, out_g_q, out_b_q;

	// apb: word index in paddr[2], low bits ignored
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == pdb_pkg::REG_IDX_MODE);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? {{(pdb_pkg::DATA_W-pdb_pkg::MODE_W){1'b0}}, blend_mode_q}
	                         : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= pdb_pkg::MODE_RESET;
		end else if (cfg_wr) begin
			blend_mode_q <= pwdata[pdb_pkg::MODE_W-1:0];
		end
	end

	// a stage moves when it is empty or the stage ahead moves
	assign adv_s3   = !out_valid_q || !out_stall;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			sa_s1   <= src_alpha;
			sr_s1   <= src_red;
			sg_s1   <= src_green;
			sb_s1   <= src_blue;
			da_s1   <= dst_alpha;
			dr_s1   <= dst_red;
			dg_s1   <= dst_green;
			db_s1   <= dst_blue;
			mode_s1 <= pdb_pkg::decode_mode(blend_mode_q);
		end
	end

	// alpha early-out flags travel beside the products
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			ctx_s2.mode    <= mode_s1;
			ctx_s2.sa_zero <= (sa_s1 == 8'h00);
			ctx_s2.sa_full <= (sa_s1 == 8'hFF);
			ctx_s2.da_zero <= (da_s1 == 8'h00);
			ctx_s2.da_full <= (da_s1 == 8'hFF);
		end
	end

	// alpha is blended as a channel with s = sa and d = da
	pdb_channel u_ch_alpha (
		.clk     (clk),
		.adv_s2  (adv_s2),
		.s_s1    (sa_s1),
		.d_s1    (da_s1),
		.sa_s1   (sa_s1),
		.da_s1   (da_s1),
		.mode_s1 (mode_s1),
		.ctx_s2  (ctx_s2),
		.res     (res_a)
	);

	pdb_channel u_ch_red (
		.clk     (clk),
		.adv_s2  (adv_s2),
		.s_s1    (sr_s1),
		.d_s1    (dr_s1),
		.sa_s1   (sa_s1),
		.da_s1   (da_s1),
		.mode_s1 (mode_s1),
		.ctx_s2  (ctx_s2),
		.res     (res_r)
	);

	pdb_channel u_ch_green (
		.clk     (clk),
		.adv_s2  (adv_s2),
		.s_s1    (sg_s1),
		.d_s1    (dg_s1),
		.sa_s1   (sa_s1),
		.da_s1   (da_s1),
		.mode_s1 (mode_s1),
		.ctx_s2  (ctx_s2),
		.res     (res_g)
	);

	pdb_channel u_ch_blue (
		.clk     (clk),
		.adv_s2  (adv_s2),
		.s_s1    (sb_s1),
		.d_s1    (db_s1),
		.sa_s1   (sa_s1),
		.da_s1   (da_s1),
		.mode_s1 (mode_s1),
		.ctx_s2  (ctx_s2),
		.res     (res_b)
	);

	// result register, holds while the consumer stalls
	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			out_a_q <= res_a;
			out_r_q <= res_r;
			out_g_q <= res_g;
			out_b_q <= res_b;
		end
	end

	assign out_valid = out_valid_q;
	assign out_alpha = out_a_q;
	assign out_red   = out_r_q;
	assign out_green = out_g_q;
	assign out_blue  = out_b_q;

	// input is held back only when every stage is full and the output stalls
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_valid_q && out_stall))
		else $error("input stalled with a free pipeline stage");

	// a new result only ever comes from an occupied combine stage
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s2))
		else $error("result appeared without an item in the combine stage");

	// clear mode always delivers a zero pixel
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && adv_s3 && ctx_s2.mode == pdb_pkg::PD_CLEAR) |=>
		(out_alpha == 8'd0 && out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
		else $error("clear mode produced a nonzero pixel");

endmodule
